>>> rtl/predset_successor_table_core_macros.svh
// Assertion macros for the successor table core.
`ifndef PREDSET_SUCCESSOR_TABLE_CORE_MACROS_SVH
`define PREDSET_SUCCESSOR_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PST_ASSERT(lbl, prop, msg)
`define PST_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/pst_pkg.sv
package pst_pkg;

  localparam int KEY_RANGE_DEF        = 1024;
  localparam int TABLE_SLOTS_DEF      = 1024;
  localparam int PROBE_LIMIT_DEF      = 8;
  localparam int ENTRIES_PER_SLOT_DEF = 4;

  localparam logic [31:0] HASH_BASIS = 32'h811c9dc5;
  localparam logic [31:0] HASH_PRIME = 32'h01000193;
  localparam logic [31:0] WEIGHT_MAX = 32'hFFFFFFFF;

  localparam logic [2:0] ST_BUMPED   = 3'd0;
  localparam logic [2:0] ST_CLAIMED  = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_DECAYED  = 3'd5;

  typedef struct packed {
    logic        op;
    logic [15:0] pred_first;
    logic [15:0] pred_second;
    logic [15:0] successor;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [1:0]  entry_index;
    logic [31:0] entry_weight;
    logic [31:0] appearance_first;
    logic [31:0] observed_count;
    logic [31:0] eviction_count;
    logic [31:0] full_count;
    logic [31:0] decay_count;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] first;
    logic [15:0] second;
  } key_t;

  typedef struct packed {
    logic [15:0] code;
    logic [31:0] weight;
  } entry_t;

endpackage

>>> rtl/predset_successor_table_core.sv
// Each accepted item passes through 8 hash rounds on one multiplier, a
// reciprocal remainder, a read per probe and a scan of ENTRIES_PER_SLOT entries.
// Rejected items go straight to the result; decay reads and writes each row once.
// One item at a time; a finished result waits in the output register.
// After rst (synchronous, active high) a clearing pass over max(TABLE_SLOTS, KEY_RANGE)
// addresses zeroes keys, entries and appearance counts; no item is taken meanwhile.
`include "predset_successor_table_core_macros.svh"

module predset_successor_table_core import pst_pkg::*; #(
  parameter int KEY_RANGE        = KEY_RANGE_DEF,
  parameter int TABLE_SLOTS      = TABLE_SLOTS_DEF,
  parameter int PROBE_LIMIT      = PROBE_LIMIT_DEF,
  parameter int ENTRIES_PER_SLOT = ENTRIES_PER_SLOT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = (KEY_RANGE > 1) ? $clog2(KEY_RANGE) : 1;
  localparam int PR_W   = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int EW     = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1;
  localparam int CLR_N  = (TABLE_SLOTS > KEY_RANGE) ? TABLE_SLOTS : KEY_RANGE;
  localparam int CLR_W  = $clog2(CLR_N);

  // hash mod TABLE_SLOTS by reciprocal: exact for any 32-bit hash
  localparam int          RECIP_K   = 32 + SLOT_W;
  localparam logic [63:0] RECIP_M64 = ((64'd1 << RECIP_K) + 64'(TABLE_SLOTS) - 64'd1) /
                                      64'(TABLE_SLOTS);
  localparam logic [32:0] RECIP_M   = RECIP_M64[32:0];

  typedef entry_t [ENTRIES_PER_SLOT-1:0] row_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_APP_A_RD, S_APP_A_WR, S_APP_B_RD, S_APP_B_WR,
    S_HASH, S_MOD, S_PR_RD, S_PR_CHK, S_SCAN, S_UPD, S_DEC_RD, S_DEC_WR, S_PUSH
  } state_t;

  state_t state;

  // memories
  key_t key_mem [TABLE_SLOTS];
  row_t row_mem [TABLE_SLOTS];
  logic [31:0] app_mem [KEY_RANGE];
  key_t key_q;
  row_t row_q;
  logic [31:0] app_q;

  logic [SLOT_W-1:0] slot_addr;
  logic [KEY_W-1:0]  app_addr;
  logic key_we, row_we, app_we;
  key_t key_wd;
  row_t row_wd;
  logic [31:0] app_wd;

  // working registers
  item_t cur;
  logic [CLR_W-1:0]  clr_cnt;
  logic [4:0]        cnt;
  logic [31:0]       h;
  logic [64:0]       prod;
  logic [SLOT_W-1:0] idx;
  logic [PR_W-1:0]   probe;
  row_t              row;
  logic              m_hit, e_hit;
  logic [EW-1:0]     m_i, e_i, low_i;
  logic [31:0]       low;
  logic [31:0]       appear;
  logic [2:0]        st_r;
  logic [SLOT_W-1:0] slot_r;
  logic [EW-1:0]     ent_r;
  logic [31:0]       wt_r;
  logic [31:0]       obs, evc, fullc, decc;

  logic        accept;
  logic [63:0] pair;
  logic [31:0] hx, hm;
  logic [31:0] quot, qn;
  entry_t      scan_e;
  row_t        row_half, row_upd;
  logic [31:0] upd_w;
  logic [EW-1:0] upd_i;
  logic        clr_slot, clr_key;
  logic [SLOT_W-1:0] idx_inc;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  assign pair   = {16'h0, cur.pred_second, 16'h0, cur.pred_first};
  assign hx     = h ^ {24'h0, pair[{cnt[2:0], 3'b000} +: 8]};
  assign hm     = 32'(hx * HASH_PRIME);
  assign quot   = 32'(prod >> RECIP_K);
  assign qn     = 32'(quot * 32'(TABLE_SLOTS));
  assign scan_e = row[cnt[EW-1:0]];
  assign idx_inc = (idx == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx + 1'b1;
  assign clr_slot = 32'(clr_cnt) < TABLE_SLOTS;
  assign clr_key  = 32'(clr_cnt) < KEY_RANGE;

  always_comb begin
    row_half = row_q;
    for (int i = 0; i < ENTRIES_PER_SLOT; i++) begin
      if (row_q[i].weight > 32'd1) row_half[i].weight = row_q[i].weight >> 1;
    end
  end

  always_comb begin
    row_upd = row;
    if (m_hit) begin
      upd_i = m_i;
      upd_w = (row[m_i].weight == WEIGHT_MAX) ? WEIGHT_MAX : row[m_i].weight + 32'd1;
    end else if (e_hit) begin
      upd_i = e_i;
      upd_w = 32'd1;
    end else begin
      upd_i = low_i;
      upd_w = (low == WEIGHT_MAX) ? WEIGHT_MAX : low + 32'd1;
    end
    row_upd[upd_i].code   = cur.successor;
    row_upd[upd_i].weight = upd_w;
  end

  always_comb begin
    slot_addr = (state == S_CLEAR) ? clr_cnt[SLOT_W-1:0] : idx;
    case (state)
      S_CLEAR:                app_addr = clr_cnt[KEY_W-1:0];
      S_APP_B_RD, S_APP_B_WR: app_addr = cur.pred_second[KEY_W-1:0];
      default:                app_addr = cur.pred_first[KEY_W-1:0];
    endcase
    key_we = 1'b0;
    key_wd = '0;
    row_we = 1'b0;
    row_wd = '0;
    app_we = 1'b0;
    app_wd = app_q + 32'd1;
    case (state)
      S_CLEAR: begin
        key_we = clr_slot;
        row_we = clr_slot;
        app_we = clr_key;
        app_wd = '0;
      end
      S_APP_A_WR, S_APP_B_WR: app_we = 1'b1;
      S_PR_CHK: begin
        key_we = !key_q.valid;
        key_wd = '{valid: 1'b1, first: cur.pred_first, second: cur.pred_second};
      end
      S_UPD: begin
        row_we = 1'b1;
        row_wd = row_upd;
      end
      S_DEC_WR: begin
        row_we = key_q.valid;
        row_wd = row_half;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[slot_addr] <= key_wd;
    key_q <= key_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[slot_addr] <= row_wd;
    row_q <= row_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (app_we) app_mem[app_addr] <= app_wd;
    app_q <= app_mem[app_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      obs          <= '0;
      evc          <= '0;
      fullc        <= '0;
      decc         <= '0;
    end else begin
      if (result_valid && result_ready && state != S_PUSH) result_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cur    <= item;
            idx    <= '0;
            slot_r <= '0;
            ent_r  <= '0;
            wt_r   <= '0;
            appear <= '0;
            if (item.op) begin
              state <= S_DEC_RD;
            end else if (32'(item.pred_first) >= KEY_RANGE ||
                         32'(item.pred_second) >= KEY_RANGE ||
                         32'(item.successor) >= KEY_RANGE) begin
              st_r  <= ST_REJECTED;
              state <= S_PUSH;
            end else begin
              state <= S_APP_A_RD;
            end
          end
        end
        S_APP_A_RD: state <= S_APP_A_WR;
        S_APP_A_WR: begin
          appear <= app_wd;
          cnt    <= '0;
          h      <= HASH_BASIS;
          state  <= (cur.pred_second != cur.pred_first) ? S_APP_B_RD : S_HASH;
        end
        S_APP_B_RD: state <= S_APP_B_WR;
        S_APP_B_WR: state <= S_HASH;
        S_HASH: begin
          cnt <= cnt + 1'b1;
          h   <= hm;
          if (cnt == 5'd7) begin
            if (hm == 32'd0) h <= 32'd1;
            cnt   <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // multiplies by the reciprocal into prod, then subtracts quotient * slots
          cnt <= cnt + 1'b1;
          if (cnt == 5'd0) begin
            prod <= {33'd0, h} * {32'd0, RECIP_M};
          end else begin
            idx   <= h[SLOT_W-1:0] - qn[SLOT_W-1:0];
            probe <= '0;
            state <= S_PR_RD;
          end
        end
        S_PR_RD: state <= S_PR_CHK;
        S_PR_CHK: begin
          if (!key_q.valid ||
              (key_q.first == cur.pred_first && key_q.second == cur.pred_second)) begin
            obs   <= obs + 32'd1;
            row   <= row_q;
            cnt   <= '0;
            m_hit <= 1'b0;
            e_hit <= 1'b0;
            low   <= row_q[0].weight;
            low_i <= '0;
            state <= S_SCAN;
          end else if (probe == PR_W'(PROBE_LIMIT - 1)) begin
            obs   <= obs + 32'd1;
            fullc <= fullc + 32'd1;
            st_r  <= ST_FULL;
            state <= S_PUSH;
          end else begin
            probe <= probe + 1'b1;
            idx   <= idx_inc;
            state <= S_PR_RD;
          end
        end
        S_SCAN: begin
          if (!m_hit && scan_e.weight != 32'd0 && scan_e.code == cur.successor) begin
            m_hit <= 1'b1;
            m_i   <= cnt[EW-1:0];
          end
          if (!e_hit && scan_e.weight == 32'd0) begin
            e_hit <= 1'b1;
            e_i   <= cnt[EW-1:0];
          end
          if (scan_e.weight < low) begin
            low   <= scan_e.weight;
            low_i <= cnt[EW-1:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'(ENTRIES_PER_SLOT - 1)) state <= S_UPD;
        end
        S_UPD: begin
          slot_r <= idx;
          ent_r  <= upd_i;
          wt_r   <= upd_w;
          if (m_hit) begin
            st_r <= ST_BUMPED;
          end else if (e_hit) begin
            st_r <= ST_CLAIMED;
          end else begin
            st_r <= ST_EVICTED;
            evc  <= evc + 32'd1;
          end
          state <= S_PUSH;
        end
        S_DEC_RD: state <= S_DEC_WR;
        S_DEC_WR: begin
          idx <= idx_inc;
          if (idx == SLOT_W'(TABLE_SLOTS - 1)) begin
            idx   <= '0;
            decc  <= decc + 32'd1;
            st_r  <= ST_DECAYED;
            state <= S_PUSH;
          end else begin
            state <= S_DEC_RD;
          end
        end
        S_PUSH: begin
          if (!result_valid || result_ready) begin
            result_valid            <= 1'b1;
            result.status           <= st_r;
            result.slot_index       <= 10'(slot_r);
            result.entry_index      <= 2'(ent_r);
            result.entry_weight     <= wt_r;
            result.appearance_first <= appear;
            result.observed_count   <= obs;
            result.eviction_count   <= evc;
            result.full_count       <= fullc;
            result.decay_count      <= decc;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PST_ASSERT(a_one_at_a_time, accept |=> !item_ready, "item taken while busy")
  `PST_ASSERT(a_no_result_in_clear, (state == S_CLEAR) |-> !result_valid,
              "result during clearing pass")
  `PST_ASSERT(a_result_from_push, $rose(result_valid) |-> $past(state == S_PUSH),
              "result raised outside push")
  `PST_ASSERT_ALWAYS(a_status_code, result_valid |-> result.status <= ST_DECAYED,
                     "undefined status code")

endmodule
